### rtl/core/sst_pkg.sv
// Package for the scoped symbol table: sizes, codes and the entry record.
// Used by the top level, which is also the user of the RAM wrapper.
`default_nettype none
package sst_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned NameBytes    = 32;
  localparam int unsigned IdxW  = $clog2(TableEntries);
  localparam int unsigned KeyW  = 256;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0, OP_LOOKUP = 2'd1, OP_ENTER = 2'd2, OP_EXIT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DUP = 2'd1, ST_FULL = 2'd2, ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PLACE, S_DONE
  } fsm_t;

  typedef struct packed {
    logic [KeyW-1:0] name;
    logic [7:0]      scope;
    logic [3:0]      kind;
    logic [31:0]     offset;
    logic [30:0]     array_length;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  function automatic logic [KeyW-1:0] normalize(input logic [KeyW-1:0] raw);
    logic [KeyW-1:0] key;
    logic            alive;
    key   = '0;
    alive = 1'b1;
    for (int k = 0; k < KeyW/8; k++) begin
      if (k >= NameBytes - 1 || raw[k*8 +: 8] == 8'd0) alive = 1'b0;
      if (alive) key[k*8 +: 8] = raw[k*8 +: 8];
    end
    return key;
  endfunction
endpackage
`default_nettype wire

### rtl/core/sst_if.sv
// Valid/ready channel interfaces for the scoped symbol table.
// Depends on sst_pkg for nothing but conventions; payload widths are fixed.
`default_nettype none
interface sst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] name_word0;
  logic [63:0] name_word1;
  logic [63:0] name_word2;
  logic [63:0] name_word3;
  logic [3:0]  sym_kind;
  logic signed [31:0] frame_offset;
  logic [7:0]  scope;
  logic [30:0] array_length;
  modport source (output valid, op, name_word0, name_word1, name_word2, name_word3,
                  sym_kind, frame_offset, scope, array_length, input ready);
  modport sink (input valid, op, name_word0, name_word1, name_word2, name_word3,
                sym_kind, frame_offset, scope, array_length, output ready);
endinterface

interface sst_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [3:0]  entry_kind;
  logic signed [31:0] entry_offset;
  logic [7:0]  entry_scope;
  logic [30:0] entry_array_length;
  logic [7:0]  scope_now;
  modport source (output valid, status, found, entry_kind, entry_offset, entry_scope,
                  entry_array_length, scope_now, input ready);
  modport sink (input valid, status, found, entry_kind, entry_offset, entry_scope,
                entry_array_length, scope_now, output ready);
endinterface
`default_nettype wire

### rtl/core/sst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/scoped_symbol_table.sv
// Scoped symbol table top level: request/response channels, entry RAM, valid
// flags, scope level and the scanning sequencer. Depends on sst_pkg, sst_if, sst_ram.
//
// One request transfer on req gives exactly one response transfer on rsp, in order.
// Requests are handled one at a time. Enter scope skips the scan: from idle it goes
// straight to the done state, which loads the response into the output register
// and returns to idle, where the next request can be taken. Add, lookup and exit
// scope stream every table entry through the one read port of the entry RAM, one
// entry a cycle, before they reach the done state. An add that places an entry
// passes through the place state, which writes the chosen slot, between the scan
// and the done state. The valid flags live in flip-flops so that the free-slot
// search and the clear on exit need no RAM access. Reset empties every slot and
// sets the scope level and the allocation hint to zero at once. The response sits
// in an output register; while the receiver stalls it holds there, the next
// request is still taken and processed, and that request then waits for the
// output register, so no further request is taken until the held response
// has transferred.
`default_nettype none
module scoped_symbol_table (
  input wire logic clk,
  input wire logic rst,
  sst_req_if.sink   req,
  sst_rsp_if.source rsp
);
  localparam int unsigned N = sst_pkg::TableEntries;
  localparam int unsigned W = sst_pkg::IdxW;

  sst_pkg::fsm_t state, state_next;
  logic [N-1:0] valid;
  logic [7:0]   nest_level;
  logic [W-1:0] free_hint;

  logic [1:0]              op;
  sst_pkg::entry_t         cur;
  logic [W:0]              rcnt;
  logic                    rd_pend;
  logic [W-1:0]            rd_idx;
  logic                    dup;
  logic                    hit;
  logic                    no_room;
  sst_pkg::entry_t         hit_e;
  logic [W-1:0]            place_idx;
  logic                    place_ok;

  sst_pkg::entry_t ram_rdata;
  logic            ram_we;

  sst_ram #(.Width(sst_pkg::EntryW), .Depth(N)) u_ram (
    .clk(clk), .we(ram_we), .waddr(place_idx), .wdata(cur),
    .raddr(rcnt[W-1:0]), .rdata(ram_rdata)
  );

  assign ram_we = (state == sst_pkg::S_PLACE);

  // First free slot at or after the hint, circularly.
  always_comb begin
    logic [W-1:0] idx;
    place_ok  = 1'b0;
    place_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      idx = free_hint + W'(i);
      if (!valid[idx]) begin
        place_ok  = 1'b1;
        place_idx = idx;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sst_pkg::S_IDLE:  if (req.valid && req.ready) begin
        state_next = (req.op == sst_pkg::OP_ENTER) ? sst_pkg::S_DONE : sst_pkg::S_SCAN;
      end
      sst_pkg::S_SCAN:  if (!rd_pend && rcnt == N[W:0]) begin
        state_next = (op == sst_pkg::OP_ADD && !dup && place_ok) ?
                     sst_pkg::S_PLACE : sst_pkg::S_DONE;
      end
      sst_pkg::S_PLACE: state_next = sst_pkg::S_DONE;
      sst_pkg::S_DONE:  if (!rsp.valid || rsp.ready) state_next = sst_pkg::S_IDLE;
      default:          state_next = sst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == sst_pkg::S_IDLE);
  end

  logic match;
  assign match = valid[rd_idx] && ram_rdata.name == cur.name;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sst_pkg::S_IDLE;
      valid       <= '0;
      nest_level  <= '0;
      free_hint   <= '0;
      rsp.valid   <= 1'b0;
      rd_pend     <= 1'b0;
      rcnt        <= '0;
    end else begin
      state <= state_next;
      if (state == sst_pkg::S_DONE && (!rsp.valid || rsp.ready)) rsp.valid <= 1'b1;
      else if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        sst_pkg::S_IDLE: if (req.valid && req.ready) begin
          op               <= req.op;
          cur.name         <= sst_pkg::normalize({req.name_word3, req.name_word2,
                                                   req.name_word1, req.name_word0});
          cur.scope        <= req.scope;
          cur.kind         <= req.sym_kind;
          cur.offset       <= req.frame_offset;
          cur.array_length <= req.array_length;
          rcnt    <= '0;
          rd_pend <= 1'b0;
          dup     <= 1'b0;
          hit     <= 1'b0;
          no_room <= 1'b0;
          if (req.op == sst_pkg::OP_ENTER && nest_level != 8'hFF)
            nest_level <= nest_level + 8'd1;
        end
        sst_pkg::S_SCAN: begin
          rd_pend <= (rcnt != N[W:0]);
          rd_idx  <= rcnt[W-1:0];
          if (rcnt != N[W:0]) rcnt <= rcnt + {{W{1'b0}}, 1'b1};
          if (rd_pend) begin
            if (match && ram_rdata.scope == cur.scope) dup <= 1'b1;
            if (match) begin
              hit   <= 1'b1;
              hit_e <= ram_rdata;
            end
            if (op == sst_pkg::OP_EXIT && nest_level != 8'd0 &&
                ram_rdata.scope == nest_level)
              valid[rd_idx] <= 1'b0;
          end
          if (!rd_pend && rcnt == N[W:0]) begin
            no_room <= !place_ok;
            if (op == sst_pkg::OP_EXIT && nest_level != 8'd0)
              nest_level <= nest_level - 8'd1;
          end
        end
        sst_pkg::S_PLACE: begin
          valid[place_idx] <= 1'b1;
          free_hint        <= place_idx + W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == sst_pkg::S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.found              <= 1'b0;
      rsp.entry_kind         <= '0;
      rsp.entry_offset       <= '0;
      rsp.entry_scope        <= '0;
      rsp.entry_array_length <= '0;
      rsp.scope_now          <= nest_level;
      rsp.status             <= sst_pkg::ST_OK;
      case (op)
        sst_pkg::OP_ADD:
          if (dup) rsp.status <= sst_pkg::ST_DUP;
          else if (no_room) rsp.status <= sst_pkg::ST_FULL;
        sst_pkg::OP_LOOKUP:
          if (hit) begin
            rsp.found              <= 1'b1;
            rsp.entry_kind         <= hit_e.kind;
            rsp.entry_offset       <= hit_e.offset;
            rsp.entry_scope        <= hit_e.scope;
            rsp.entry_array_length <= hit_e.array_length;
          end else begin
            rsp.status <= sst_pkg::ST_NOT_FOUND;
          end
        default: ;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != sst_pkg::S_IDLE) |-> !req.ready) else $error("request taken while busy");
  a_place_free: assert property (@(posedge clk) disable iff (rst)
    (state == sst_pkg::S_PLACE) |-> !valid[place_idx]) else $error("slot in use");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.status) &&
    $stable(rsp.scope_now) && $stable(rsp.entry_offset)))
    else $error("response dropped while stalled");
endmodule
`default_nettype wire
